[design/epsd_pkg.sv]
// escaped patch stream decoder: shared types and constants
// parse phase codes, decoder state and result structs; no dependencies
package epsd_pkg;

    localparam logic [2:0] PH_PLAIN  = 3'd0;
    localparam logic [2:0] PH_ESC    = 3'd1;
    localparam logic [2:0] PH_SKIP16 = 3'd2;
    localparam logic [2:0] PH_SKIP32 = 3'd3;

    localparam logic [7:0]  ESC_BYTE  = 8'hFF;
    localparam logic [15:0] LONG_MARK = 16'hFFFF;
    localparam logic [31:0] END_MARK  = 32'hFFFF_FFFF;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_END   = 1'b1;

    typedef struct packed {
        logic [2:0]  phase;
        logic [31:0] position;
        logic [31:0] gathered;
        logic [1:0]  count;
    } epsd_state_t;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [31:0] target_offset;
        logic [7:0]  write_value;
    } epsd_result_t;

endpackage

[design/epsd_step.sv]
// escaped patch stream decoder: next-state and result logic for one script byte
// depends on epsd_pkg
module epsd_step
    import epsd_pkg::*;
(
    input  epsd_state_t  cur_state,
    input  logic [7:0]   script_byte,
    output epsd_state_t  next_state,
    output epsd_result_t result
);

    logic [15:0] g16;
    logic [31:0] g32;

    assign g16 = {cur_state.gathered[7:0], script_byte};
    assign g32 = {cur_state.gathered[23:0], script_byte};

    always_comb begin
        next_state = cur_state;
        result     = '0;
        unique case (cur_state.phase)
            PH_ESC: begin
                if (script_byte == 8'h00) begin
                    result.valid         = 1'b1;
                    result.kind          = KIND_WRITE;
                    result.target_offset = cur_state.position;
                    result.write_value   = ESC_BYTE;
                    next_state.position  = cur_state.position + 32'd1;
                    next_state.phase     = PH_PLAIN;
                end else if (script_byte == ESC_BYTE) begin
                    next_state.phase    = PH_SKIP16;
                    next_state.gathered = '0;
                    next_state.count    = '0;
                end else begin
                    next_state.position = cur_state.position + {24'd0, script_byte};
                    next_state.phase    = PH_PLAIN;
                end
            end
            PH_SKIP16: begin
                if (cur_state.count == 2'd0) begin
                    next_state.gathered = {16'd0, g16};
                    next_state.count    = 2'd1;
                end else if (g16 == LONG_MARK) begin
                    next_state.phase    = PH_SKIP32;
                    next_state.gathered = '0;
                    next_state.count    = '0;
                end else begin
                    next_state.position = cur_state.position + {16'd0, g16};
                    next_state.phase    = PH_PLAIN;
                    next_state.gathered = '0;
                    next_state.count    = '0;
                end
            end
            PH_SKIP32: begin
                if (cur_state.count != 2'd3) begin
                    next_state.gathered = g32;
                    next_state.count    = cur_state.count + 2'd1;
                end else if (g32 == END_MARK) begin
                    // end of script: back to a fresh start at offset zero
                    next_state.phase    = PH_PLAIN;
                    next_state.position = '0;
                    next_state.gathered = '0;
                    next_state.count    = '0;
                    result.valid        = 1'b1;
                    result.kind         = KIND_END;
                end else begin
                    next_state.position = cur_state.position + g32;
                    next_state.phase    = PH_PLAIN;
                    next_state.gathered = '0;
                    next_state.count    = '0;
                end
            end
            default: begin
                // plain phase, unused codes behave the same
                if (script_byte == ESC_BYTE) begin
                    next_state.phase = PH_ESC;
                end else begin
                    next_state.phase     = PH_PLAIN;
                    result.valid         = 1'b1;
                    result.kind          = KIND_WRITE;
                    result.target_offset = cur_state.position;
                    result.write_value   = script_byte;
                    next_state.position  = cur_state.position + 32'd1;
                end
            end
        endcase
    end

endmodule

[design/escaped_patch_stream_decoder.sv]
// a byte is registered in the input stage, its result (if any) in the output stage
// throughput: one byte per cycle unless m_tready stalls; the decode of a byte is a
// phase decision plus one 32-bit offset add between the input and result registers
// reset (aresetn low, synchronous): both stages empty, plain phase, offset zero
// top level of the escaped patch stream decoder; depends on epsd_pkg, epsd_step
module escaped_patch_stream_decoder
    import epsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] script_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] target_offset, [39:32] write_value
    output logic        m_tuser    // [0] kind
);

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg, in_byte_next;
    epsd_state_t  state_reg, state_next;
    logic         out_valid_reg, out_valid_next;
    logic         out_kind_reg, out_kind_next;
    logic [31:0]  out_offset_reg, out_offset_next;
    logic [7:0]   out_value_reg, out_value_next;

    epsd_state_t  step_state;
    epsd_result_t step_result;
    logic         out_free;
    logic         decode_fire;

    epsd_step u_step (
        .cur_state   (state_reg),
        .script_byte (in_byte_reg),
        .next_state  (step_state),
        .result      (step_result)
    );

    assign out_free    = !out_valid_reg || m_tready;
    assign decode_fire = in_valid_reg && out_free;
    assign s_tready    = !in_valid_reg || out_free;

    always_comb begin
        in_valid_next   = in_valid_reg;
        in_byte_next    = in_byte_reg;
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_offset_next = out_offset_reg;
        out_value_next  = out_value_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (decode_fire) begin
            state_next = step_state;
            in_valid_next = 1'b0;
            if (step_result.valid) begin
                out_valid_next  = 1'b1;
                out_kind_next   = step_result.kind;
                out_offset_next = step_result.target_offset;
                out_value_next  = step_result.write_value;
            end
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            state_reg.phase    <= PH_PLAIN;
            state_reg.position <= '0;
            state_reg.gathered <= '0;
            state_reg.count    <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
        in_byte_reg    <= in_byte_next;
        out_kind_reg   <= out_kind_next;
        out_offset_reg <= out_offset_next;
        out_value_reg  <= out_value_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_value_reg, out_offset_reg};

`ifndef SYNTHESIS
    a_end_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_END) |-> (m_tdata == 40'd0))
        else $error("end transaction carries nonzero data");

    a_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (decode_fire && step_result.valid && step_result.kind == KIND_END)
        |=> (state_reg.position == 32'd0 && state_reg.phase == PH_PLAIN))
        else $error("decoder did not restart after end of script");

    a_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_PLAIN || state_reg.phase == PH_ESC)
        |-> (state_reg.count == 2'd0))
        else $error("gather count left over outside a skip phase");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (decode_fire && step_result.valid) |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while held");
`endif

endmodule
